### rtl/core/eewf_pkg.sv
// Shared widths and the square-root cell word of the edge-weight filter.
`default_nettype none
package eewf_pkg;

    localparam int COORD_BITS  = 16;
    localparam int INDEX_BITS  = 16;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int SUM_BITS    = 2 * COORD_BITS + 2;
    localparam int ROOT_BITS   = COORD_BITS + 1;
    localparam int REM_BITS    = COORD_BITS + 4;
    localparam int SQRT_STEPS  = SUM_BITS / 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = ROOT_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_DIMENSION = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BYPASS    = 2'd2;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [INDEX_BITS-1:0] t_index;
    typedef logic [SQ_BITS-1:0]    t_square;

    // One word moving down the square-root chain.
    typedef struct packed {
        logic                  valid;
        t_index                src;
        t_index                tgt;
        logic [SUM_BITS-1:0]   rad;
        logic [REM_BITS-1:0]   rem;
        logic [ROOT_BITS-1:0]  root;
    } t_cell;

endpackage
`default_nettype wire

### rtl/core/eewf_sq_lane.sv
// One coordinate lane: absolute difference and its square, registered.
`default_nettype none
module eewf_sq_lane (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire eewf_pkg::t_coord i_a,
    input  wire eewf_pkg::t_coord i_b,
    output eewf_pkg::t_square     o_sq
);
    import eewf_pkg::*;

    t_coord  diff;
    t_square r_sq;

    assign diff = (i_a >= i_b) ? (i_a - i_b) : (i_b - i_a);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= SQ_BITS'(diff) * SQ_BITS'(diff);
        end
    end

    assign o_sq = r_sq;
endmodule
`default_nettype wire

### rtl/core/eewf_sqrt_cell.sv
// One restoring square-root step: takes the next radicand digit pair.
`default_nettype none
module eewf_sqrt_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire eewf_pkg::t_cell i_cell,
    output eewf_pkg::t_cell      o_cell
);
    import eewf_pkg::*;

    logic [REM_BITS-1:0] rem_sh;
    logic [REM_BITS-1:0] trial;
    logic                fits;
    t_cell               n_cell;
    t_cell               r_cell;

    always_comb begin
        rem_sh = {i_cell.rem[REM_BITS-3:0], i_cell.rad[SUM_BITS-1 -: 2]};
        trial  = {{(REM_BITS-2-ROOT_BITS){1'b0}}, i_cell.root, 2'b01};
        fits   = (rem_sh >= trial);
        n_cell       = i_cell;
        n_cell.rad   = {i_cell.rad[SUM_BITS-3:0], 2'b00};
        n_cell.rem   = fits ? (rem_sh - trial) : rem_sh;
        n_cell.root  = {i_cell.root[ROOT_BITS-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_en) begin
            r_cell.src  <= n_cell.src;
            r_cell.tgt  <= n_cell.tgt;
            r_cell.rad  <= n_cell.rad;
            r_cell.rem  <= n_cell.rem;
            r_cell.root <= n_cell.root;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

### rtl/core/euclidean_edge_weight_filter_core.sv
// Top level of the Euclidean edge-weight filter: lanes, adder and root chain.
//
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_stall   i_edge_source .. i_b_z
//  out       source     o_out_valid / i_out_stall o_out_source .. o_keep_edge
//  cfg       sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
// One word is taken per cycle while the pipeline is not stalled. The edge that
// accepts a word loads the squaring lanes, the sum register follows, then one
// cell per root digit in the 17-cell chain, the last of which is the output.
// Reset is synchronous and empties the pipeline; the registers return to
// dimension 2, threshold all ones and pruning on.
// An output stall on a valid word freezes the whole pipeline; o_in_stall follows it.
`default_nettype none
module euclidean_edge_weight_filter_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire eewf_pkg::t_index                      i_edge_source,
    input  wire eewf_pkg::t_index                      i_edge_target,
    input  wire eewf_pkg::t_coord                      i_a_w,
    input  wire eewf_pkg::t_coord                      i_a_x,
    input  wire eewf_pkg::t_coord                      i_a_y,
    input  wire eewf_pkg::t_coord                      i_a_z,
    input  wire eewf_pkg::t_coord                      i_b_w,
    input  wire eewf_pkg::t_coord                      i_b_x,
    input  wire eewf_pkg::t_coord                      i_b_y,
    input  wire eewf_pkg::t_coord                      i_b_z,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output eewf_pkg::t_index                           o_out_source,
    output eewf_pkg::t_index                           o_out_target,
    output logic [eewf_pkg::ROOT_BITS-1:0]             o_edge_weight,
    output logic                                       o_keep_edge,
    input  wire logic                                  i_cfg_we,
    input  wire logic [eewf_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire logic [eewf_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);
    import eewf_pkg::*;

    logic                  dim_is_3;
    logic [2:0]            r_dimension;
    logic [ROOT_BITS-1:0]  r_threshold;
    logic                  r_prune_bypass;

    logic                  adv;
    logic                  r_s1_valid;
    t_index                r_s1_src;
    t_index                r_s1_tgt;
    t_square               sq_w, sq_x, sq_y, sq_z;
    logic                  use_z, use_w;
    logic [SUM_BITS-1:0]   sum;
    t_cell                 r_s2;
    t_cell                 chain [0:SQRT_STEPS];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension    <= 3'd2;
            r_threshold    <= '1;
            r_prune_bypass <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DIMENSION: r_dimension    <= i_cfg_data[2:0];
                REG_THRESHOLD: r_threshold    <= i_cfg_data[ROOT_BITS-1:0];
                REG_BYPASS:    r_prune_bypass <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    assign dim_is_3 = (r_dimension == 3'd3);

    // The pipeline moves as one unless a finished word is held at the output.
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    eewf_sq_lane u_lane_w (.i_clk, .i_en(adv), .i_a(i_a_w), .i_b(i_b_w), .o_sq(sq_w));
    eewf_sq_lane u_lane_x (.i_clk, .i_en(adv), .i_a(i_a_x), .i_b(i_b_x), .o_sq(sq_x));
    eewf_sq_lane u_lane_y (.i_clk, .i_en(adv), .i_a(i_a_y), .i_b(i_b_y), .o_sq(sq_y));
    eewf_sq_lane u_lane_z (.i_clk, .i_en(adv), .i_a(i_a_z), .i_b(i_b_z), .o_sq(sq_z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_in_valid;
        end
        if (adv) begin
            r_s1_src <= i_edge_source;
            r_s1_tgt <= i_edge_target;
        end
    end

    // Any dimension code other than three or four falls back to the plane.
    assign use_z = dim_is_3 || (r_dimension == 3'd4);
    assign use_w = (r_dimension == 3'd4);

    assign sum = SUM_BITS'(sq_x) + SUM_BITS'(sq_y)
               + (use_z ? SUM_BITS'(sq_z) : '0)
               + (use_w ? SUM_BITS'(sq_w) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (adv) begin
            r_s2.valid <= r_s1_valid;
        end
        if (adv) begin
            r_s2.src  <= r_s1_src;
            r_s2.tgt  <= r_s1_tgt;
            r_s2.rad  <= sum;
            r_s2.rem  <= '0;
            r_s2.root <= '0;
        end
    end

    assign chain[0] = r_s2;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_cell
        eewf_sqrt_cell u_cell (
            .i_clk,
            .i_rst_n,
            .i_en   (adv),
            .i_cell (chain[g]),
            .o_cell (chain[g+1])
        );
    end

    assign o_out_valid   = chain[SQRT_STEPS].valid;
    assign o_out_source  = chain[SQRT_STEPS].src;
    assign o_out_target  = chain[SQRT_STEPS].tgt;
    assign o_edge_weight = chain[SQRT_STEPS].root;
    assign o_keep_edge   = r_prune_bypass || (o_edge_weight <= r_threshold);

`ifndef ASSERT_OFF
    a_reset_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output word valid straight after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held output word");

    a_prune_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_keep_edge) |-> (!r_prune_bypass && o_edge_weight > r_threshold))
        else $error("word pruned against the threshold rule");

    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_edge_weight)))
        else $error("held output word changed under stall");
`endif
endmodule
`default_nettype wire
